@@ rtl/core/ring_buffer_bulk_put_get_assert.svh @@
// Assertion macros used by the ring buffer RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef RING_BUFFER_BULK_PUT_GET_ASSERT_SVH
`define RING_BUFFER_BULK_PUT_GET_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a condition at every clock edge out of reset.
`define RBPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define RBPG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define RBPG_ASSERT(lbl, prop, msg)
`define RBPG_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/core/rbpg_pkg.sv @@
// Package for the ring buffer with bulk put and get.
// Holds field widths, codes and the controller/datapath command and status types.
package rbpg_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int CNT_W         = 7;
    localparam int IO_WORD_W     = 32;
    localparam int MAX_RES       = 64;

    localparam logic [CNT_W-1:0] SEEN_MAX = 7'd127;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic put_acc;   // a put word is taken this cycle
        logic get_acc;   // a get request is taken this cycle
        logic rd_issue;  // read one ring word into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;   // output register empty or being drained
        logic grant_zero;  // the get on the input would grant nothing
        logic left_one;    // the read now issued is the last of the get
    } t_sts;

endpackage

@@ rtl/core/rbpg_if.sv @@
// Valid/ready channel interfaces for the ring buffer.
// Depends on rbpg_pkg for the field widths.
interface rbpg_in_if
    import rbpg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [CNT_W-1:0]     count;
    logic                 refuse_short;
    logic [IO_WORD_W-1:0] put_word;
    logic                 final_word;

    modport source (output valid, kind, count, refuse_short, put_word, final_word, input ready);
    modport sink   (input valid, kind, count, refuse_short, put_word, final_word, output ready);
endinterface

interface rbpg_out_if
    import rbpg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 from_get;
    logic [CNT_W-1:0]     done_count;
    logic [IO_WORD_W-1:0] got_word;
    logic                 run_end;

    modport source (output valid, from_get, done_count, got_word, run_end, input ready);
    modport sink   (input valid, from_get, done_count, got_word, run_end, output ready);
endinterface

@@ rtl/core/rbpg_ctrl.sv @@
// Controller of the ring buffer: accepts beats and sequences get read-out.
// Depends on rbpg_pkg for t_cmd and t_sts.
module rbpg_ctrl
    import rbpg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_kind,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        w_accept     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = i_sts.slot_free;
                w_accept      = i_in_valid && i_sts.slot_free;
                o_cmd.put_acc = w_accept && (i_kind == KIND_PUT);
                o_cmd.get_acc = w_accept && (i_kind == KIND_GET);
                if (o_cmd.get_acc && !i_sts.grant_zero) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                // one word per free output slot; drop back after the last
                o_cmd.rd_issue = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.left_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/rbpg_dp.sv @@
// Datapath of the ring buffer: ring memory, pointers, put run state,
// get read-out counters and the output register. Depends on rbpg_pkg.
`include "ring_buffer_bulk_put_get_assert.svh"

module rbpg_dp
    import rbpg_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_refuse_short,
    input  logic [IO_WORD_W-1:0] i_put_word,
    input  logic                 i_final_word,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_from_get,
    output logic [CNT_W-1:0]     o_done_count,
    output logic [IO_WORD_W-1:0] o_got_word,
    output logic                 o_run_end
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW   = PW + 1;
    localparam int LW   = (AW > CNT_W) ? AW : CNT_W;
    localparam int KEEP = (WORD_BITS < IO_WORD_W) ? WORD_BITS : IO_WORD_W;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [PW-1:0]    r_head, r_rcur, r_tail, r_idx;
    logic [PW-1:0]    n_head, n_rcur, n_tail, n_idx;
    logic             r_put_active, n_put_active;
    logic [CNT_W-1:0] r_put_allowed, n_put_allowed;
    logic [CNT_W-1:0] r_put_seen, n_put_seen;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_grant, n_grant;

    logic             r_out_valid, n_out_valid;
    logic             r_from_get, n_from_get;
    logic [CNT_W-1:0] r_done, n_done;
    logic             r_run_end, n_run_end;
    logic             r_word_en, n_word_en;

    logic [AW-1:0]    w_free, w_avail;
    logic [LW-1:0]    w_min;
    logic [CNT_W-1:0] w_allow, w_grant;
    logic [CNT_W-1:0] w_base_allowed, w_base_seen;
    logic             w_wr_en, w_load;
    logic [PW-1:0]    w_tail_inc, w_idx_inc;

    assign w_tail_inc = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_idx_inc  = (r_idx  == PW'(DEPTH - 1)) ? '0 : r_idx + 1'b1;

    // Free space seen by the first word of a put run
    always_comb begin
        if (r_head > r_tail) begin
            w_free = AW'(r_head) - AW'(r_tail) - AW'(1);
        end else begin
            w_free = AW'(r_head) + AW'(DEPTH) - AW'(r_tail) - AW'(1);
        end
        if (i_count == '0) begin
            w_allow = '0;
        end else if (LW'(w_free) < LW'(i_count)) begin
            w_allow = i_refuse_short ? '0 : CNT_W'(w_free);
        end else begin
            w_allow = i_count;
        end
    end

    // Readable run after the release: up to tail or the ring end
    always_comb begin
        if (r_rcur == r_tail) begin
            w_avail = '0;
        end else if (r_rcur < r_tail) begin
            w_avail = AW'(r_tail) - AW'(r_rcur);
        end else begin
            w_avail = AW'(DEPTH) - AW'(r_rcur);
        end
        w_min = (LW'(i_count) < LW'(w_avail)) ? LW'(i_count) : LW'(w_avail);
        if (w_min > LW'(MAX_RES)) begin
            w_min = LW'(MAX_RES);
        end
        w_grant = CNT_W'(w_min);
    end

    assign w_base_allowed = r_put_active ? r_put_allowed : w_allow;
    assign w_base_seen    = r_put_active ? r_put_seen : '0;
    assign w_wr_en        = i_cmd.put_acc && (w_base_seen < w_base_allowed);

    assign o_sts.slot_free  = !r_out_valid || i_out_ready;
    assign o_sts.grant_zero = (w_grant == '0);
    assign o_sts.left_one   = (r_left == CNT_W'(1));

    always_comb begin
        n_head        = r_head;
        n_rcur        = r_rcur;
        n_tail        = r_tail;
        n_idx         = r_idx;
        n_put_active  = r_put_active;
        n_put_allowed = r_put_allowed;
        n_put_seen    = r_put_seen;
        n_left        = r_left;
        n_grant       = r_grant;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_from_get    = r_from_get;
        n_done        = r_done;
        n_run_end     = r_run_end;
        n_word_en     = r_word_en;
        w_load        = 1'b0;

        if (i_cmd.put_acc) begin
            n_put_allowed = w_base_allowed;
            n_put_seen    = (w_base_seen < SEEN_MAX) ? w_base_seen + 1'b1 : w_base_seen;
            n_put_active  = !i_final_word;
            if (w_wr_en) begin
                n_tail = w_tail_inc;
            end
            if (i_final_word) begin
                w_load     = 1'b1;
                n_from_get = 1'b0;
                n_done     = w_base_allowed;
                n_run_end  = 1'b1;
                n_word_en  = 1'b0;
            end
        end

        if (i_cmd.get_acc) begin
            // release the region handed out by the previous get
            n_head  = r_rcur;
            n_idx   = r_rcur;
            n_left  = w_grant;
            n_grant = w_grant;
            if (w_grant == '0) begin
                w_load     = 1'b1;
                n_from_get = 1'b1;
                n_done     = '0;
                n_run_end  = 1'b1;
                n_word_en  = 1'b0;
            end
        end

        if (i_cmd.rd_issue) begin
            w_load     = 1'b1;
            n_from_get = 1'b1;
            n_done     = r_grant;
            n_run_end  = (r_left == CNT_W'(1));
            n_word_en  = 1'b1;
            n_idx      = w_idx_inc;
            n_left     = r_left - 1'b1;
            if (r_left == CNT_W'(1)) begin
                n_rcur = w_idx_inc;
            end
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_rcur        <= '0;
            r_tail        <= '0;
            r_idx         <= '0;
            r_put_active  <= 1'b0;
            r_put_allowed <= '0;
            r_put_seen    <= '0;
            r_left        <= '0;
            r_grant       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_rcur        <= n_rcur;
            r_tail        <= n_tail;
            r_idx         <= n_idx;
            r_put_active  <= n_put_active;
            r_put_allowed <= n_put_allowed;
            r_put_seen    <= n_put_seen;
            r_left        <= n_left;
            r_grant       <= n_grant;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from_get <= n_from_get;
        r_done     <= n_done;
        r_run_end  <= n_run_end;
        r_word_en  <= n_word_en;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= WORD_BITS'(i_put_word[KEEP-1:0]);
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_from_get   = r_from_get;
    assign o_done_count = r_done;
    assign o_run_end    = r_run_end;
    assign o_got_word   = r_word_en ? IO_WORD_W'(r_rd_data[KEEP-1:0]) : '0;

    `RBPG_ASSERT(a_no_overwrite, !w_load || !r_out_valid || i_out_ready, "result overwritten")
    `RBPG_ASSERT(a_rd_left, !i_cmd.rd_issue || (r_left != '0), "read past grant")
    `RBPG_ASSERT(a_left_bound, (r_left <= r_grant) && (r_grant <= CNT_W'(MAX_RES)), "bad grant")
    `RBPG_ASSERT_NEXT(a_keep_gap, w_wr_en, r_tail != r_head, "ring overfilled")

endmodule

@@ rtl/core/ring_buffer_bulk_put_get.sv @@
// Ring buffer with bulk put and get - top level.
// Depends on rbpg_pkg, rbpg_if, rbpg_ctrl and rbpg_dp.
//
// A ring of DEPTH words with one slot kept free. A put call arrives as a run
// of put beats (kind = 0), one data word each; the first beat of a run sizes
// the call against the free space (refused whole when refuse_short is set,
// clipped otherwise), surplus words are dropped, and the beat with final_word
// set returns one completion carrying the accepted count. A get beat (kind = 1)
// first releases the region of the previous get, then returns up to count
// words (at most 64) from the contiguous region before the ring end or the
// tail, one result beat per word with run_end on the last; a get granting
// nothing returns a single empty result. A get is sized when taken, then its
// granted words are read one per free output slot, paced by the single read
// port of the ring memory, whose registered read data is the output register.
// A new input beat is taken only while the output register is empty or being
// drained in the same cycle, and never during a get read-out. No clearing pass
// is needed after reset: reads only reach written entries.
module ring_buffer_bulk_put_get
    import rbpg_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbpg_in_if.sink    i_in,
    rbpg_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: owns the input handshake and paces the get read-out
    rbpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: ring memory, pointers and the output register
    rbpg_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_count        (i_in.count),
        .i_refuse_short (i_in.refuse_short),
        .i_put_word     (i_in.put_word),
        .i_final_word   (i_in.final_word),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_from_get     (o_out.from_get),
        .o_done_count   (o_out.done_count),
        .o_got_word     (o_out.got_word),
        .o_run_end      (o_out.run_end)
    );

endmodule

@@ test/tb_ring_buffer_bulk_put_get.sv @@
// Self-checking testbench for the ring buffer with bulk put and get.
// Depends on rbpg_pkg, the rbpg_in_if/rbpg_out_if channels and ring_buffer_bulk_put_get.
`timescale 1ns / 1ps

module tb_ring_buffer_bulk_put_get;
    import rbpg_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int WORD_BITS     = WORD_BITS_DEF;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int ITEM_BUDGET   = 400;
    localparam int QUIET_TAIL    = 60;        // last beats sent with no idling
    localparam int LONG_RUN      = 130;       // put run long enough to saturate the word tally
    localparam int SETTLE_CYCLES = 80;        // longer than a full 64-word read-out
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // One input beat and one result beat, at the channel widths
    typedef struct packed {
        logic                 kind;
        logic [CNT_W-1:0]     count;
        logic                 refuse_short;
        logic [IO_WORD_W-1:0] put_word;
        logic                 final_word;
    } ring_beat_t;

    typedef struct packed {
        logic                 from_get;
        logic [CNT_W-1:0]     done_count;
        logic [IO_WORD_W-1:0] got_word;
        logic                 run_end;
    } ring_result_t;

    // Directed row: a beat, and where the outcome is obvious, the single result it must give
    typedef struct packed {
        ring_beat_t   beat;
        logic         typed;
        ring_result_t want;
    } plan_row_t;

    localparam ring_result_t EMPTY_GET = '{1'b1, 7'd0, 32'h0, 1'b1};
    localparam ring_result_t NO_RESULT = '0;
    localparam int PLAN_ROWS = 21;

    // Walk from reset: empty gets, a three-word put over the data extremes, partial and
    // oversized gets, a zero-count put, a refused and a clipped put, surplus words dropped,
    // a get that lands in the middle of an open put, and a get on a drained ring.
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{'{KIND_GET, 7'd5,   1'b0, 32'h0000_0000, 1'b0}, 1'b1, EMPTY_GET},
        '{'{KIND_GET, 7'd0,   1'b0, 32'h0000_0000, 1'b0}, 1'b1, EMPTY_GET},
        '{'{KIND_PUT, 7'd3,   1'b0, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd3,   1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd3,   1'b0, 32'hA5A5_A5A5, 1'b1}, 1'b1, '{1'b0, 7'd3, 32'h0, 1'b1}},
        '{'{KIND_GET, 7'd2,   1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_GET, 7'd127, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd0,   1'b0, 32'h1234_5678, 1'b1}, 1'b1, '{1'b0, 7'd0, 32'h0, 1'b1}},
        '{'{KIND_PUT, 7'd64,  1'b1, 32'h8765_4321, 1'b1}, 1'b1, '{1'b0, 7'd0, 32'h0, 1'b1}},
        '{'{KIND_PUT, 7'd64,  1'b0, 32'h5A5A_5A5A, 1'b1}, 1'b1, '{1'b0, 7'd62, 32'h0, 1'b1}},
        '{'{KIND_PUT, 7'd1,   1'b1, 32'h0F0F_0F0F, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd127, 1'b1, 32'hF0F0_F0F0, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd0,   1'b0, 32'h1111_1111, 1'b1}, 1'b1, '{1'b0, 7'd1, 32'h0, 1'b1}},
        '{'{KIND_GET, 7'd64,  1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd4,   1'b1, 32'h0000_0001, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_GET, 7'd10,  1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd4,   1'b0, 32'h0000_0002, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_PUT, 7'd4,   1'b0, 32'h0000_0003, 1'b1}, 1'b1, '{1'b0, 7'd4, 32'h0, 1'b1}},
        '{'{KIND_GET, 7'd1,   1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_GET, 7'd127, 1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_RESULT},
        '{'{KIND_GET, 7'd3,   1'b0, 32'h0000_0000, 1'b0}, 1'b1, EMPTY_GET}
    };

    logic i_clk;
    logic i_rst_n;

    rbpg_in_if  in_ch ();
    rbpg_out_if out_ch ();

    ring_buffer_bulk_put_get #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow of the ring: contents, pointers and the state of an open put run
    logic [WORD_BITS-1:0] ring_store [DEPTH];
    logic [PTR_W-1:0]     head_q      = '0;
    logic [PTR_W-1:0]     read_q      = '0;
    logic [PTR_W-1:0]     tail_q      = '0;
    logic                 run_open    = 1'b0;
    logic [CNT_W-1:0]     run_allowed = '0;
    logic [CNT_W-1:0]     run_seen    = '0;

    ring_result_t fresh_results [$];    // results of the beat just accepted
    ring_result_t pending_results [$];  // results still owed by the block, oldest first

    int  beats_sent  = 0;
    int  fault_count = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;   // no idling on either side from here on
    bit  idle_on     = 1'b1;   // idling allowed in the current stretch

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Work out the results of one accepted beat and advance the shadow state.
    function automatic void ring_predict(input ring_beat_t b);
        int           free_slots;
        int           allow;
        int           avail;
        int           grant;
        ring_result_t r;

        if (b.kind == KIND_GET) begin
            // Release the region of the previous get first
            head_q = read_q;
            if (head_q == tail_q) begin
                avail = 0;
            end else if (head_q < tail_q) begin
                avail = int'(tail_q) - int'(head_q);
            end else begin
                avail = DEPTH - int'(head_q);   // stop at the ring end
            end
            grant = (int'(b.count) < avail) ? int'(b.count) : avail;
            if (grant > MAX_RES) begin
                grant = MAX_RES;
            end
            if (grant == 0) begin
                fresh_results.push_back(EMPTY_GET);
            end else begin
                for (int i = 0; i < grant; i++) begin
                    r.from_get   = 1'b1;
                    r.done_count = CNT_W'(grant);
                    r.got_word   = IO_WORD_W'(ring_store[(int'(head_q) + i) % DEPTH]);
                    r.run_end    = (i + 1 == grant);
                    fresh_results.push_back(r);
                end
                read_q = PTR_W'((int'(head_q) + grant) % DEPTH);
            end
        end else begin
            // The first word of a run sizes the whole call against the free space
            if (!run_open) begin
                free_slots = (int'(head_q) + DEPTH - int'(tail_q) - 1) % DEPTH;
                if (b.count == '0) begin
                    allow = 0;
                end else if (free_slots < int'(b.count)) begin
                    allow = b.refuse_short ? 0 : free_slots;
                end else begin
                    allow = int'(b.count);
                end
                run_allowed = CNT_W'(allow);
                run_seen    = '0;
                run_open    = 1'b1;
            end
            if (run_seen < run_allowed) begin
                ring_store[tail_q] = b.put_word[WORD_BITS-1:0];
                tail_q             = PTR_W'((int'(tail_q) + 1) % DEPTH);
            end
            if (run_seen < SEEN_MAX) begin
                run_seen = run_seen + 1'b1;
            end
            if (b.final_word) begin
                run_open   = 1'b0;
                r.from_get   = 1'b0;
                r.done_count = run_allowed;
                r.got_word   = '0;
                r.run_end    = 1'b1;
                fresh_results.push_back(r);
            end
        end
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    // Offer one beat, optionally after an idle burst, and hold it until taken.
    // A typed row replaces the predicted results with the one it states.
    task automatic push_beat(input ring_beat_t b, input logic typed, input ring_result_t want);
        int gap;

        if (beats_sent % 40 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
        end
        if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= b.kind;
        in_ch.count        <= b.count;
        in_ch.refuse_short <= b.refuse_short;
        in_ch.put_word     <= b.put_word;
        in_ch.final_word   <= b.final_word;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        beats_sent++;
        fresh_results.delete();
        ring_predict(b);
        if (typed) begin
            fresh_results.delete();
            fresh_results.push_back(want);
        end
        foreach (fresh_results[k]) begin
            pending_results.push_back(fresh_results[k]);
        end
    endtask

    // Send one put call as a run of words; later words mostly repeat the call's fields.
    task automatic send_put_run(input int cnt, input logic fm, input int words);
        ring_beat_t b;

        for (int w = 0; w < words; w++) begin
            b.kind         = KIND_PUT;
            b.count        = (w == 0 || $urandom_range(0, 9) != 0) ?
                             CNT_W'(cnt) : CNT_W'($urandom_range(0, 127));
            b.refuse_short = (w == 0 || $urandom_range(0, 9) != 0) ? fm : ~fm;
            b.put_word     = $urandom;
            b.final_word   = (w == words - 1);
            push_beat(b, 1'b0, NO_RESULT);
        end
    endtask

    // Result side: check every beat taken, then pick next cycle's ready
    initial begin
        ring_result_t got;
        ring_result_t want;
        int           stall_left;

        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.from_get, out_ch.done_count, out_ch.got_word, out_ch.run_end};
                if (pending_results.size() == 0) begin
                    report_fault($sformatf("unexpected result: from_get=%0b count=%0d word=%h end=%0b",
                                           got.from_get, got.done_count, got.got_word,
                                           got.run_end));
                end else begin
                    want = pending_results.pop_front();
                    if (got.from_get !== want.from_get || got.done_count !== want.done_count ||
                        got.got_word !== want.got_word || got.run_end !== want.run_end) begin
                        report_fault($sformatf({"result mismatch: expected from_get=%0b ",
                                                "count=%0d word=%h end=%0b, got from_get=%0b ",
                                                "count=%0d word=%h end=%0b"},
                                               want.from_get, want.done_count, want.got_word,
                                               want.run_end, got.from_get, got.done_count,
                                               got.got_word, got.run_end));
                    end
                end
            end
            // Stall in bursts while idling is allowed
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 11);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up well past the slowest correct run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus: directed walk, then random calls, then drain and report
    initial begin
        ring_beat_t b;
        int         choice;
        int         pick;
        int         cnt;
        int         words;
        bit         paused;
        bit         long_done;

        paused             = 1'b0;
        long_done          = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_PUT;
        in_ch.count        <= '0;
        in_ch.refuse_short <= 1'b0;
        in_ch.put_word     <= '0;
        in_ch.final_word   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            push_beat(PLAN[r].beat, PLAN[r].typed, PLAN[r].want);
        end

        while (beats_sent < ITEM_BUDGET) begin
            if (beats_sent >= ITEM_BUDGET - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            // Hold off once until the block has handed back everything owed
            if (!paused && beats_sent >= ITEM_BUDGET / 2) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            // One very long run drives the word tally into saturation
            if (!long_done && beats_sent >= 120) begin
                long_done = 1'b1;
                send_put_run(3, 1'($urandom_range(0, 1)), LONG_RUN);
            end

            choice = $urandom_range(0, 99);
            pick   = $urandom_range(0, 99);
            if (choice < 55) begin
                if (pick < 50) begin
                    cnt = $urandom_range(1, 8);
                end else if (pick < 75) begin
                    cnt = $urandom_range(9, 24);
                end else if (pick < 90) begin
                    cnt = $urandom_range(25, 64);
                end else if (pick < 95) begin
                    cnt = 0;
                end else begin
                    cnt = $urandom_range(65, 127);
                end
                words = (cnt == 0) ? $urandom_range(1, 3) : ((cnt > 70) ? 70 : cnt);
                case ($urandom_range(0, 9))
                    0: begin
                        words = $urandom_range(1, words);        // short run
                    end
                    1: begin
                        words = words + $urandom_range(1, 5);    // surplus words
                    end
                    default: begin
                    end
                endcase
                send_put_run(cnt, 1'($urandom_range(0, 1)), words);
            end else if (choice < 93) begin
                if (pick < 70) begin
                    cnt = $urandom_range(1, 16);
                end else if (pick < 90) begin
                    cnt = $urandom_range(17, 64);
                end else if (pick < 95) begin
                    cnt = 0;
                end else begin
                    cnt = $urandom_range(65, 127);
                end
                b.kind         = KIND_GET;
                b.count        = CNT_W'(cnt);
                b.refuse_short = 1'($urandom_range(0, 1));
                b.put_word     = $urandom;
                b.final_word   = 1'($urandom_range(0, 1));
                push_beat(b, 1'b0, NO_RESULT);
            end else begin
                // Stray beat with every field random; may open or close a run out of turn
                b.kind         = 1'($urandom_range(0, 1));
                b.count        = CNT_W'($urandom_range(0, 127));
                b.refuse_short = 1'($urandom_range(0, 1));
                b.put_word     = $urandom;
                b.final_word   = 1'($urandom_range(0, 1));
                push_beat(b, 1'b0, NO_RESULT);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
